// ===== sv/bba_pkg.sv =====
// Shared types, codes and constants of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int LEVELS_DEF          = 8;
  localparam int MIN_BLOCK_BYTES_DEF = 64;
  localparam int SIZE_LVL_W          = 5;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_FAIL  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [15:0] size_bytes;
    logic [6:0]  block_offset;
  } req_t;

  typedef struct packed {
    logic       status;
    logic [6:0] granted_offset;
  } res_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_CHECK, ST_POP_RD, ST_POP_WB, ST_SPLIT,
    ST_FCLR, ST_FLOOP, ST_FCHK, ST_WALK, ST_STEP_WB, ST_UNL_WB, ST_MERGE,
    ST_PUSH, ST_RESP_OK, ST_RESP_FAIL
  } ctl_state_e;

  typedef enum logic [3:0] {
    DP_NOP, DP_CLEAR, DP_LOAD, DP_DECODE, DP_CHECK, DP_POP_RD, DP_POP_WB,
    DP_SPLIT, DP_FCLR, DP_FBUDDY, DP_STEP_RD, DP_STEP_WB, DP_UNL_RD,
    DP_UNL_WB, DP_MERGE, DP_PUSH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   res_valid;
    logic   res_fail;
  } ctl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic bad;
    logic k_gt_lvl;
    logic k_last;
    logic buddy_used;
    logic walk_end;
    logic match;
    logic clear_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== sv/buddy_block_allocator_unit.sv =====
// Top level of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over 2^(LEVELS-1) minimum blocks.
// Request channel: drive req_i and raise start; the request is taken at a
// clock edge where start is high and busy is low. op selects allocate or
// free; sizes are in bytes, offsets in minimum blocks.
// Result channel: res_o is valid for exactly one cycle while res_valid_o is
// high; the receiver cannot stall it and must take it in that cycle.
// One request at a time: busy stays high from acceptance until the result
// cycle. An allocate splits the block it takes once per level down to the
// requested level, at most LEVELS-1 times. A free pushes the block at once
// when it starts at the top level or when the buddy is allocated, and walks
// the free list through the link memory when the buddy is not; each buddy
// found there is unlinked and merged, one level up at a time.
// Failed checks answer straight from the check state.
// Reset: the top level holds the whole pool, the other lists are empty.
// After reset a clearing pass zeroes all 2^(clog2(LEVELS)+LEVELS-1) allocation
// marks (1024 at LEVELS = 8); busy is high meanwhile.
module buddy_block_allocator_unit import bba_pkg::*; #(
  parameter int LEVELS          = LEVELS_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output res_t      res_o,
  output logic      res_valid_o
);

  ctl_cmd_t   cmd;
  dp_status_t dp_status;

  bba_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .status_i(dp_status),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  bba_datapath #(
    .LEVELS         (LEVELS),
    .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_i),
    .cmd_i   (cmd),
    .status_o(dp_status),
    .res_o   (res_o)
  );

  assign res_valid_o = cmd.res_valid;

`ifndef ASSERT_OFF
  // a result strobe lasts one cycle and frees the block next cycle
  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o && !busy)
    else $error("result strobe longer than one cycle");

  // results only come while a request is in flight
  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result without request");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !res_valid_o)
    else $error("request not taken");
`endif

endmodule
`default_nettype wire

// ===== sv/bba_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, hold data when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bba_datapath.sv =====
// Datapath of the buddy allocator: free lists, link and mark memories.
`timescale 1ns / 1ps
`default_nettype none
module bba_datapath import bba_pkg::*; #(
  parameter int LEVELS          = LEVELS_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire req_t       req_i,
  input  wire ctl_cmd_t   cmd_i,
  output dp_status_t      status_o,
  output res_t            res_o
);

  localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int OW   = LEVELS - 1;
  localparam int AW   = LW + OW;
  localparam int POOL = 1 << OW;
  localparam int CW   = OW + 1;

  req_t                  req_q, req_d;
  logic [SIZE_LVL_W-1:0] lvl_q, lvl_d;
  logic [LW-1:0]         k_q, k_d;
  logic [OW-1:0]         o_q, o_d;
  logic [OW-1:0]         cur_q, cur_d;
  logic [OW-1:0]         prev_q, prev_d;
  logic                  have_prev_q, have_prev_d;
  logic                  walk_valid_q, walk_valid_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [OW-1:0]         head_q [LEVELS];
  logic [OW-1:0]         head_d [LEVELS];
  logic [LEVELS-1:0]     hv_q, hv_d;
  logic                  link0_q, link0_d;
  logic [OW-1:0]         rd_addr_q, rd_addr_d;
  logic [AW-1:0]         clr_q, clr_d;

  logic          l_we, l_re;
  logic [OW-1:0] l_waddr, l_raddr;
  logic [OW:0]   l_wdata, l_rdata;
  logic          a_we, a_re;
  logic [AW-1:0] a_waddr, a_raddr;
  logic          a_wdata, a_rdata;

  logic [15:0]           size_m1;
  logic [4:0]            size_exp;
  logic [SIZE_LVL_W-1:0] lvl_w;
  logic [OW+6:0]         off_wide;
  logic [OW-1:0]         off_ext;
  logic                  off_big, lvl_big, found;
  logic [LW-1:0]         found_k, lvl_k, km1;
  logic [OW-1:0]         oi, bi, q_w, split_idx, split_blk, rd_link, head_idx;
  logic                  rd_valid, is_free;
  logic [OW+6:0]         o_wide;

  bba_ram #(.WIDTH(OW + 1), .DEPTH(POOL)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_waddr),
    .wdata_i(l_wdata),
    .re_i   (l_re),
    .raddr_i(l_raddr),
    .rdata_o(l_rdata)
  );

  bba_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_mark_ram (
    .clk_i  (clk_i),
    .we_i   (a_we),
    .waddr_i(a_waddr),
    .wdata_i(a_wdata),
    .re_i   (a_re),
    .raddr_i(a_raddr),
    .rdata_o(a_rdata)
  );

  // map byte size to a level: ceil log2, then scale by the minimum block
  always_comb begin
    size_m1  = req_q.size_bytes - 16'd1;
    size_exp = '0;
    for (int i = 0; i < 16; i++) begin
      if (size_m1[i]) begin
        size_exp = 5'(i + 1);
      end
    end
    if (req_q.size_bytes <= 16'd1) begin
      size_exp = '0;
    end
    lvl_w = '0;
    for (int j = 1; j <= 16; j++) begin
      if ((32'd1 << size_exp) >= (32'(MIN_BLOCK_BYTES) << j)) begin
        lvl_w = SIZE_LVL_W'(j);
      end
    end
  end

  // request checks and the lowest nonempty level at or above the request
  always_comb begin
    off_wide = {{OW{1'b0}}, req_q.block_offset};
    off_ext  = off_wide[OW-1:0];
    off_big  = (off_wide >> OW) != '0;
    lvl_big  = int'(lvl_q) >= LEVELS;
    lvl_k    = lvl_q[LW-1:0];
    is_free  = req_q.op == OP_FREE;
    found    = 1'b0;
    found_k  = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (!found && hv_q[i] && i >= int'(lvl_q)) begin
        found   = 1'b1;
        found_k = LW'(i);
      end
    end
  end

  // block index, buddy and split arithmetic
  always_comb begin
    oi        = OW'(o_q >> k_q);
    bi        = oi ^ OW'(1);
    q_w       = OW'(bi << k_q);
    km1       = k_q - LW'(1);
    split_idx = OW'(o_q >> km1);
    split_blk = o_q + (OW'(1) << km1);
    head_idx  = OW'(head_q[k_q] >> k_q);
    rd_link   = l_rdata[OW-1:0];
    rd_valid  = l_rdata[OW] & ((rd_addr_q != '0) | link0_q);
  end

  // execute the command of the controller
  always_comb begin
    req_d        = req_q;
    lvl_d        = lvl_q;
    k_d          = k_q;
    o_d          = o_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    walk_valid_d = walk_valid_q;
    cnt_d        = cnt_q;
    head_d       = head_q;
    hv_d         = hv_q;
    clr_d        = clr_q;
    l_we         = 1'b0;
    l_waddr      = '0;
    l_wdata      = '0;
    l_re         = 1'b0;
    l_raddr      = '0;
    a_we         = 1'b0;
    a_waddr      = '0;
    a_wdata      = 1'b0;
    a_re         = 1'b0;
    a_raddr      = '0;
    unique case (cmd_i.op)
      DP_NOP: begin
      end
      DP_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_q;
        clr_d   = clr_q + AW'(1);
      end
      DP_LOAD: begin
        req_d = req_i;
      end
      DP_DECODE: begin
        lvl_d = lvl_w;
      end
      DP_CHECK: begin
        k_d = is_free ? lvl_k : found_k;
        o_d = off_ext;
      end
      DP_POP_RD: begin
        o_d     = head_q[k_q];
        l_re    = 1'b1;
        l_raddr = head_q[k_q];
        a_we    = 1'b1;
        a_waddr = {k_q, head_idx};
        a_wdata = 1'b1;
      end
      DP_POP_WB: begin
        head_d[k_q] = rd_link;
        hv_d[k_q]   = rd_valid;
      end
      DP_SPLIT: begin
        a_we        = 1'b1;
        a_waddr     = {km1, split_idx};
        a_wdata     = 1'b1;
        l_we        = 1'b1;
        l_waddr     = split_blk;
        l_wdata     = {hv_q[km1], head_q[km1]};
        head_d[km1] = split_blk;
        hv_d[km1]   = 1'b1;
        k_d         = km1;
      end
      DP_FCLR: begin
        a_we    = 1'b1;
        a_waddr = {k_q, oi};
      end
      DP_FBUDDY: begin
        a_we         = 1'b1;
        a_waddr      = {k_q, oi};
        a_re         = 1'b1;
        a_raddr      = {k_q, bi};
        cur_d        = head_q[k_q];
        walk_valid_d = hv_q[k_q];
        have_prev_d  = 1'b0;
        cnt_d        = '0;
      end
      DP_STEP_RD: begin
        l_re        = 1'b1;
        l_raddr     = cur_q;
        prev_d      = cur_q;
        have_prev_d = 1'b1;
        cnt_d       = cnt_q + CW'(1);
      end
      DP_STEP_WB: begin
        walk_valid_d = rd_valid;
        cur_d        = rd_link;
      end
      DP_UNL_RD: begin
        l_re    = 1'b1;
        l_raddr = cur_q;
      end
      DP_UNL_WB: begin
        if (!have_prev_q) begin
          head_d[k_q] = rd_link;
          hv_d[k_q]   = rd_valid;
        end else begin
          l_we    = 1'b1;
          l_waddr = prev_q;
          l_wdata = {rd_valid, rd_link};
        end
      end
      DP_MERGE: begin
        l_we    = 1'b1;
        l_waddr = cur_q;
        l_wdata = {1'b0, rd_link};
        if (!bi[0]) begin
          o_d = q_w;
        end
        k_d = k_q + LW'(1);
      end
      DP_PUSH: begin
        l_we        = 1'b1;
        l_waddr     = o_q;
        l_wdata     = {hv_q[k_q], head_q[k_q]};
        head_d[k_q] = o_q;
        hv_d[k_q]   = 1'b1;
      end
      default: begin
      end
    endcase
    link0_d   = link0_q | (l_we && l_waddr == '0);
    rd_addr_d = l_re ? l_raddr : rd_addr_q;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LEVELS; i++) begin
        head_q[i] <= '0;
      end
      hv_q         <= LEVELS'(1) << (LEVELS - 1);
      link0_q      <= 1'b0;
      clr_q        <= '0;
      cnt_q        <= '0;
      have_prev_q  <= 1'b0;
      walk_valid_q <= 1'b0;
    end else begin
      head_q       <= head_d;
      hv_q         <= hv_d;
      link0_q      <= link0_d;
      clr_q        <= clr_d;
      cnt_q        <= cnt_d;
      have_prev_q  <= have_prev_d;
      walk_valid_q <= walk_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    lvl_q     <= lvl_d;
    k_q       <= k_d;
    o_q       <= o_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    rd_addr_q <= rd_addr_d;
  end

  // status back to the controller
  always_comb begin
    status_o.is_free    = is_free;
    status_o.bad        = is_free ? (lvl_big | off_big)
                                  : ((req_q.size_bytes == '0) | lvl_big | !found);
    status_o.k_gt_lvl   = k_q > lvl_k;
    status_o.k_last     = k_q == LW'(LEVELS - 1);
    status_o.buddy_used = a_rdata;
    status_o.walk_end   = !walk_valid_q || cnt_q == CW'(POOL);
    status_o.match      = cur_q == q_w;
    status_o.clear_last = &clr_q;
  end

  // result fields
  always_comb begin
    o_wide        = {7'b0, o_q};
    res_o.status  = cmd_i.res_fail ? ST_FAIL : ST_OK;
    if (is_free) begin
      res_o.granted_offset = req_q.block_offset;
    end else if (cmd_i.res_fail) begin
      res_o.granted_offset = '0;
    end else begin
      res_o.granted_offset = o_wide[6:0];
    end
  end

endmodule
`default_nettype wire

// ===== sv/bba_ctrl.sv =====
// Controller state machine of the buddy allocator.
`timescale 1ns / 1ps
`default_nettype none
module bba_ctrl import bba_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire dp_status_t status_i,
  output ctl_cmd_t        cmd_o,
  output logic            busy_o
);

  ctl_state_e state_q, state_d;

  // hold state, enter the clearing pass at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:     if (status_i.clear_last) state_d = ST_IDLE;
      ST_IDLE:      if (start_i) state_d = ST_DECODE;
      ST_DECODE:    state_d = ST_CHECK;
      ST_CHECK: begin
        if (status_i.bad) state_d = ST_RESP_FAIL;
        else if (status_i.is_free) state_d = ST_FCLR;
        else state_d = ST_POP_RD;
      end
      ST_POP_RD:    state_d = ST_POP_WB;
      ST_POP_WB:    state_d = ST_SPLIT;
      ST_SPLIT:     if (!status_i.k_gt_lvl) state_d = ST_RESP_OK;
      ST_FCLR:      state_d = ST_FLOOP;
      ST_FLOOP:     state_d = status_i.k_last ? ST_PUSH : ST_FCHK;
      ST_FCHK:      state_d = status_i.buddy_used ? ST_PUSH : ST_WALK;
      ST_WALK: begin
        if (status_i.walk_end) state_d = ST_PUSH;
        else if (status_i.match) state_d = ST_UNL_WB;
        else state_d = ST_STEP_WB;
      end
      ST_STEP_WB:   state_d = ST_WALK;
      ST_UNL_WB:    state_d = ST_MERGE;
      ST_MERGE:     state_d = ST_FLOOP;
      ST_PUSH:      state_d = ST_RESP_OK;
      ST_RESP_OK:   state_d = ST_IDLE;
      ST_RESP_FAIL: state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // datapath commands and result strobe
  always_comb begin
    cmd_o.op        = DP_NOP;
    cmd_o.res_valid = 1'b0;
    cmd_o.res_fail  = 1'b0;
    busy_o          = state_q != ST_IDLE;
    unique case (state_q)
      ST_CLEAR:   cmd_o.op = DP_CLEAR;
      ST_IDLE:    if (start_i) cmd_o.op = DP_LOAD;
      ST_DECODE:  cmd_o.op = DP_DECODE;
      ST_CHECK:   cmd_o.op = DP_CHECK;
      ST_POP_RD:  cmd_o.op = DP_POP_RD;
      ST_POP_WB:  cmd_o.op = DP_POP_WB;
      ST_SPLIT:   if (status_i.k_gt_lvl) cmd_o.op = DP_SPLIT;
      ST_FCLR:    cmd_o.op = DP_FCLR;
      ST_FLOOP:   if (!status_i.k_last) cmd_o.op = DP_FBUDDY;
      ST_FCHK:    cmd_o.op = DP_NOP;
      ST_WALK: begin
        if (!status_i.walk_end) begin
          cmd_o.op = status_i.match ? DP_UNL_RD : DP_STEP_RD;
        end
      end
      ST_STEP_WB: cmd_o.op = DP_STEP_WB;
      ST_UNL_WB:  cmd_o.op = DP_UNL_WB;
      ST_MERGE:   cmd_o.op = DP_MERGE;
      ST_PUSH:    cmd_o.op = DP_PUSH;
      ST_RESP_OK: cmd_o.res_valid = 1'b1;
      ST_RESP_FAIL: begin
        cmd_o.res_valid = 1'b1;
        cmd_o.res_fail  = 1'b1;
      end
      default:    cmd_o.op = DP_NOP;
    endcase
  end

endmodule
`default_nettype wire
